// File: src/mmts_pkg.sv
// ----------------------------------------------------------------------------
// mmts_pkg
// Shared types, codes and default sizes of the modbus master scheduler.
// ----------------------------------------------------------------------------
package mmts_pkg;

   localparam int HIGH_QUEUE_BYTES_DEFAULT = 512;
   localparam int LOW_QUEUE_BYTES_DEFAULT  = 512;
   localparam int MAX_FRAME_BYTES_DEFAULT  = 256;
   localparam int RECEIVE_LIMIT_DEFAULT    = 256;

   localparam int CMD_W    = 2;
   localparam int KIND_W   = 2;
   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 9;
   localparam int ADDR_W   = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RX_BYTE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_TX_DONE = 2'd3;

   localparam logic [KIND_W-1:0] KIND_TX_BYTE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RX_BYTE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DONE    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_TIMEOUT = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_GAP  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RESP_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SILENCE    = 2'd2;

   localparam logic [CSR_DATA_W-1:0] FRAME_GAP_RESET  = 16'd4;
   localparam logic [CSR_DATA_W-1:0] RESP_LIMIT_RESET = 16'd1000;
   localparam logic [CSR_DATA_W-1:0] SILENCE_RESET    = 16'd10;

   typedef enum logic [3:0] {
      MODE_IDLE      = 4'b0001,
      MODE_SILENCE   = 4'b0010,
      MODE_SENDING   = 4'b0100,
      MODE_RECEIVING = 4'b1000
   } mode_type;

   typedef enum logic [5:0] {
      EN_DECODE = 6'b000001,
      EN_HDR0   = 6'b000010,
      EN_HDR1   = 6'b000100,
      EN_EMIT   = 6'b001000,
      EN_STAGE1 = 6'b010000,
      EN_COMMIT = 6'b100000
   } eng_type;

   typedef enum logic [1:0] {
      SRC_NONE   = 2'd0,
      SRC_DIRECT = 2'd1,
      SRC_HIGH   = 2'd2,
      SRC_LOW    = 2'd3
   } src_type;

   typedef enum logic [2:0] {
      RC_PENDING = 3'd0,
      RC_DIRECT  = 3'd1,
      RC_HIGH    = 3'd2,
      RC_LOW     = 3'd3,
      RC_DROP    = 3'd4
   } req_class_type;

   typedef struct packed {
      logic [BYTE_W-1:0] sid;
      logic [BYTE_W-1:0] fc;
      logic [ADDR_W-1:0] addr;
   } hdr_type;

   function automatic req_class_type classify(input logic [BYTE_W-1:0] code);
      req_class_type c;
      c = RC_DROP;
      if (code == 8'd5 || code == 8'd6 || code == 8'd15 || code == 8'd16) begin
         c = RC_HIGH;
      end else if (code >= 8'd1 && code <= 8'd4) begin
         c = RC_LOW;
      end
      return c;
   endfunction

endpackage

// File: src/mmts_req_if.sv
// ----------------------------------------------------------------------------
// mmts_req_if
// Request channel: commands, request bytes and received bus bytes.
// ----------------------------------------------------------------------------
interface mmts_req_if;
   logic                            valid;
   logic                            ready;
   logic [mmts_pkg::CMD_W-1:0]      command;
   logic [mmts_pkg::BYTE_W-1:0]     data_byte;
   logic                            last_byte;

   modport source (output valid, output command, output data_byte, output last_byte,
                   input ready);
   modport sink   (input valid, input command, input data_byte, input last_byte,
                   output ready);
endinterface

// File: src/mmts_rsp_if.sv
// ----------------------------------------------------------------------------
// mmts_rsp_if
// Result channel: transmit bytes, reply bytes and reply outcome.
// ----------------------------------------------------------------------------
interface mmts_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [mmts_pkg::KIND_W-1:0]     kind;
   logic [mmts_pkg::BYTE_W-1:0]     out_byte;
   logic                            frame_end;
   logic [mmts_pkg::LEN_W-1:0]      reply_length;
   logic [mmts_pkg::BYTE_W-1:0]     slave_id;
   logic [mmts_pkg::BYTE_W-1:0]     function_code;
   logic [mmts_pkg::ADDR_W-1:0]     start_address;

   modport source (output valid, output kind, output out_byte, output frame_end,
                   output reply_length, output slave_id, output function_code,
                   output start_address, input ready);
   modport sink   (input valid, input kind, input out_byte, input frame_end,
                   input reply_length, input slave_id, input function_code,
                   input start_address, output ready);
endinterface

// File: src/mmts_ram.sv
// ----------------------------------------------------------------------------
// mmts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mmts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: src/modbus_master_transaction_scheduler_unit.sv
// ----------------------------------------------------------------------------
// modbus_master_transaction_scheduler_unit
// Modbus RTU master sequencer: direct send, two priority byte queues,
// reply streaming with gap and response timers, bus silence.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | beat
//  req     | in        | valid/ready        | command, data_byte, last_byte
//  rsp     | out       | valid/ready        | kind, byte, frame_end, length, header
//  csr     | in        | csr_we, no wait    | csr_index, csr_wdata
//
//  ticks, reply bytes, transmit done and direct request bytes: decode state only.
//  a queued transmit byte: decode, then emit (queue memory read latency).
//  a frame start from a queue: two header reads (hdr0, hdr1), then the first byte.
//  a request byte into a queue: decode, plus stage1 on the code byte, commit on the last.
//  reset is synchronous and needs no clearing pass; the queue memories hold
//  nothing until written. a beat waits in the input register while a result
//  sits in the output register, and no further beat is taken meanwhile.
module modbus_master_transaction_scheduler_unit #(
   parameter int HIGH_QUEUE_BYTES = mmts_pkg::HIGH_QUEUE_BYTES_DEFAULT,
   parameter int LOW_QUEUE_BYTES  = mmts_pkg::LOW_QUEUE_BYTES_DEFAULT,
   parameter int MAX_FRAME_BYTES  = mmts_pkg::MAX_FRAME_BYTES_DEFAULT,
   parameter int RECEIVE_LIMIT    = mmts_pkg::RECEIVE_LIMIT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   mmts_req_if.sink                            req,
   mmts_rsp_if.source                          rsp,
   input  logic                                csr_we,
   input  logic [mmts_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mmts_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int QMAX = (HIGH_QUEUE_BYTES > LOW_QUEUE_BYTES) ? HIGH_QUEUE_BYTES
                                                              : LOW_QUEUE_BYTES;
   localparam int QW   = $clog2(QMAX + 1);
   localparam int CNTW = $clog2(MAX_FRAME_BYTES + 2);
   localparam int SW   = ((QW > CNTW) ? QW : CNTW) + 1;
   localparam int RW   = $clog2(RECEIVE_LIMIT + 1);
   localparam int HAW  = $clog2(HIGH_QUEUE_BYTES);
   localparam int LAW  = $clog2(LOW_QUEUE_BYTES);
   localparam logic [QW-1:0] HSIZE = QW'(HIGH_QUEUE_BYTES);
   localparam logic [QW-1:0] LSIZE = QW'(LOW_QUEUE_BYTES);

   localparam int B = mmts_pkg::BYTE_W;

   function automatic logic [QW-1:0] wrap_add(input logic [SW-1:0] p,
                                             input logic [SW-1:0] n,
                                             input logic [SW-1:0] size);
      logic [SW-1:0] s;
      s = p + n;
      if (s >= size) begin
         s = s - size;
      end
      return s[QW-1:0];
   endfunction

   function automatic logic stage_fits(input logic [CNTW-1:0] idx,
                                       input logic [QW-1:0] fill,
                                       input logic [QW-1:0] size);
      logic [SW-1:0] free_b;
      free_b = SW'(size) - SW'(fill);
      return (SW'(idx) + SW'(1) <= SW'(MAX_FRAME_BYTES)) &&
             (SW'(idx) + SW'(5) < free_b);
   endfunction

   function automatic mmts_pkg::hdr_type latch_hdr(input mmts_pkg::hdr_type h,
                                                    input logic [CNTW-1:0] pos,
                                                    input logic [B-1:0] b);
      mmts_pkg::hdr_type r;
      r = h;
      if (pos == CNTW'(0)) begin
         r.sid = b;
      end else if (pos == CNTW'(1)) begin
         r.fc = b;
      end else if (pos == CNTW'(2)) begin
         r.addr[15:8] = b;
      end else if (pos == CNTW'(3)) begin
         r.addr[7:0] = b;
      end
      return r;
   endfunction

   // configuration
   logic [15:0] frame_gap_ff, resp_limit_ff, silence_ticks_ff;

   // input register
   logic                        hold_valid_ff;
   logic [mmts_pkg::CMD_W-1:0]  hold_cmd_ff;
   logic [B-1:0]                hold_byte_ff;
   logic                        hold_last_ff;

   // scheduler state
   mmts_pkg::mode_type       mode_ff, mode_in;
   mmts_pkg::eng_type        eng_ff, eng_in;
   logic [QW-1:0]            hq_rd_ff, hq_rd_in, hq_wr_ff, hq_wr_in, hq_fill_ff, hq_fill_in;
   logic [QW-1:0]            lq_rd_ff, lq_rd_in, lq_wr_ff, lq_wr_in, lq_fill_ff, lq_fill_in;
   logic                     req_active_ff, req_active_in, req_over_ff, req_over_in;
   mmts_pkg::req_class_type  req_class_ff, req_class_in;
   logic [CNTW-1:0]          req_count_ff, req_count_in;
   logic [B-1:0]             req_first_ff, req_first_in;
   mmts_pkg::src_type        out_src_ff, out_src_in;
   logic [QW-1:0]            out_rem_ff, out_rem_in;
   logic [2:0]               out_pos_ff, out_pos_in;
   logic [RW-1:0]            reply_ff, reply_in;
   logic                     gap_armed_ff, gap_armed_in, resp_armed_ff, resp_armed_in;
   logic [15:0]              gap_cnt_ff, gap_cnt_in, resp_cnt_ff, resp_cnt_in;
   logic [15:0]              sil_cnt_ff, sil_cnt_in;
   mmts_pkg::hdr_type        hdr_ff, hdr_in;
   logic [1:0]               cmt_k_ff, cmt_k_in;
   logic [B-1:0]             len_lo_ff, len_lo_in;

   // result register
   logic                        rsp_valid_ff;
   logic [mmts_pkg::KIND_W-1:0] rsp_kind_ff, res_kind;
   logic [B-1:0]                rsp_byte_ff, res_byte;
   logic                        rsp_fe_ff, res_fe;
   logic [mmts_pkg::LEN_W-1:0]  rsp_len_ff, res_len;
   mmts_pkg::hdr_type           rsp_hdr_ff;
   logic                        res_load, item_done, out_free, start;

   // queue memories
   logic          mem_we, mem_we_high;
   logic [QW-1:0] mem_waddr, mem_raddr;
   logic [B-1:0]  mem_wdata, h_rdata, l_rdata;

   mmts_ram #(.WIDTH(B), .DEPTH(HIGH_QUEUE_BYTES)) u_high_ram (
      .clock (clock),
      .we    (mem_we && mem_we_high),
      .waddr (mem_waddr[HAW-1:0]),
      .wdata (mem_wdata),
      .raddr (mem_raddr[HAW-1:0]),
      .rdata (h_rdata)
   );

   mmts_ram #(.WIDTH(B), .DEPTH(LOW_QUEUE_BYTES)) u_low_ram (
      .clock (clock),
      .we    (mem_we && !mem_we_high),
      .waddr (mem_waddr[LAW-1:0]),
      .wdata (mem_wdata),
      .raddr (mem_raddr[LAW-1:0]),
      .rdata (l_rdata)
   );

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign start     = (eng_ff == mmts_pkg::EN_DECODE) && hold_valid_ff && out_free;
   assign req.ready = !hold_valid_ff || item_done;

   always_comb begin
      logic          s_high, c_high, do_start, defer, fits;
      logic [QW-1:0] s_rd, s_fill, c_wr, c_fill, c_size, rd4, fill4, rem_v;
      logic [15:0]   len16;
      logic [B-1:0]  rq, b;
      logic [CNTW-1:0] idx;

      mode_in       = mode_ff;
      eng_in        = eng_ff;
      hq_rd_in      = hq_rd_ff;
      hq_wr_in      = hq_wr_ff;
      hq_fill_in    = hq_fill_ff;
      lq_rd_in      = lq_rd_ff;
      lq_wr_in      = lq_wr_ff;
      lq_fill_in    = lq_fill_ff;
      req_active_in = req_active_ff;
      req_over_in   = req_over_ff;
      req_class_in  = req_class_ff;
      req_count_in  = req_count_ff;
      req_first_in  = req_first_ff;
      out_src_in    = out_src_ff;
      out_rem_in    = out_rem_ff;
      out_pos_in    = out_pos_ff;
      reply_in      = reply_ff;
      gap_armed_in  = gap_armed_ff;
      resp_armed_in = resp_armed_ff;
      gap_cnt_in    = gap_cnt_ff;
      resp_cnt_in   = resp_cnt_ff;
      sil_cnt_in    = sil_cnt_ff;
      hdr_in        = hdr_ff;
      cmt_k_in      = cmt_k_ff;
      len_lo_in     = len_lo_ff;
      res_load      = 1'b0;
      res_kind      = mmts_pkg::KIND_TX_BYTE;
      res_byte      = '0;
      res_fe        = 1'b0;
      res_len       = '0;
      item_done     = 1'b0;
      mem_we        = 1'b0;
      mem_we_high   = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = '0;
      do_start      = 1'b0;
      defer         = 1'b0;
      fits          = 1'b0;
      idx           = '0;
      b             = hold_byte_ff;

      s_high    = (out_src_ff == mmts_pkg::SRC_HIGH);
      s_rd      = s_high ? hq_rd_ff : lq_rd_ff;
      s_fill    = s_high ? hq_fill_ff : lq_fill_ff;
      rq        = s_high ? h_rdata : l_rdata;
      mem_raddr = s_rd;
      rd4       = wrap_add(SW'(s_rd), SW'(4), SW'(s_high ? HSIZE : LSIZE));
      fill4     = s_fill - QW'(4);
      len16     = {rq, len_lo_ff};
      rem_v     = (len16 > 16'(fill4)) ? fill4 : QW'(len16);

      unique case (eng_ff)
         mmts_pkg::EN_DECODE: begin
            if (start) begin
               unique case (hold_cmd_ff)
                  mmts_pkg::CMD_TICK: begin
                     unique case (mode_ff)
                        mmts_pkg::MODE_RECEIVING: begin
                           item_done = 1'b1;
                           if (gap_armed_ff) begin
                              if (gap_cnt_ff >= frame_gap_ff) begin
                                 res_load      = 1'b1;
                                 res_kind      = mmts_pkg::KIND_DONE;
                                 res_len       = mmts_pkg::LEN_W'(reply_ff);
                                 gap_armed_in  = 1'b0;
                                 resp_armed_in = 1'b0;
                                 reply_in      = '0;
                                 mode_in       = mmts_pkg::MODE_SILENCE;
                                 sil_cnt_in    = silence_ticks_ff;
                              end else begin
                                 gap_cnt_in = gap_cnt_ff + 16'd1;
                              end
                           end else if (resp_armed_ff) begin
                              if (resp_cnt_ff >= resp_limit_ff) begin
                                 res_load      = 1'b1;
                                 res_kind      = mmts_pkg::KIND_TIMEOUT;
                                 res_len       = mmts_pkg::LEN_W'(reply_ff);
                                 resp_armed_in = 1'b0;
                                 mode_in       = mmts_pkg::MODE_SILENCE;
                                 sil_cnt_in    = silence_ticks_ff;
                              end else begin
                                 resp_cnt_in = resp_cnt_ff + 16'd1;
                              end
                           end
                        end
                        mmts_pkg::MODE_SILENCE: begin
                           if (sil_cnt_ff == 16'd0) begin
                              do_start = 1'b1;
                           end else begin
                              sil_cnt_in = sil_cnt_ff - 16'd1;
                              item_done  = 1'b1;
                           end
                        end
                        mmts_pkg::MODE_SENDING: begin
                           if ((out_src_ff == mmts_pkg::SRC_HIGH ||
                                out_src_ff == mmts_pkg::SRC_LOW) && out_rem_ff != '0) begin
                              eng_in = mmts_pkg::EN_EMIT;
                           end else begin
                              item_done = 1'b1;
                           end
                        end
                        default: begin
                           if (hq_fill_ff >= QW'(4) || lq_fill_ff >= QW'(4)) begin
                              do_start = 1'b1;
                           end else begin
                              item_done = 1'b1;
                           end
                        end
                     endcase
                     // pick the next queued frame, high queue first
                     if (do_start) begin
                        if (hq_fill_ff >= QW'(4)) begin
                           out_src_in = mmts_pkg::SRC_HIGH;
                           mem_raddr  = hq_rd_ff;
                           eng_in     = mmts_pkg::EN_HDR0;
                        end else if (lq_fill_ff >= QW'(4)) begin
                           out_src_in = mmts_pkg::SRC_LOW;
                           mem_raddr  = lq_rd_ff;
                           eng_in     = mmts_pkg::EN_HDR0;
                        end else begin
                           mode_in   = mmts_pkg::MODE_IDLE;
                           item_done = 1'b1;
                        end
                     end
                  end
                  mmts_pkg::CMD_REQUEST: begin
                     if (!req_active_ff) begin
                        req_active_in = 1'b1;
                        req_over_in   = 1'b0;
                        req_count_in  = '0;
                        if (mode_ff == mmts_pkg::MODE_IDLE) begin
                           req_class_in = mmts_pkg::RC_DIRECT;
                           mode_in      = mmts_pkg::MODE_SENDING;
                           out_src_in   = mmts_pkg::SRC_DIRECT;
                           out_rem_in   = '0;
                           out_pos_in   = '0;
                           hdr_in       = '0;
                        end else begin
                           req_class_in = mmts_pkg::RC_PENDING;
                        end
                     end
                     idx = req_count_in;
                     if (req_class_in == mmts_pkg::RC_DIRECT) begin
                        if (mode_in == mmts_pkg::MODE_SENDING &&
                            out_src_in == mmts_pkg::SRC_DIRECT) begin
                           hdr_in   = latch_hdr(hdr_in, idx, b);
                           res_load = 1'b1;
                           res_kind = mmts_pkg::KIND_TX_BYTE;
                           res_byte = b;
                           res_fe   = hold_last_ff;
                        end
                     end else if (req_class_in == mmts_pkg::RC_PENDING) begin
                        if (idx == '0) begin
                           req_first_in = b;
                        end else begin
                           req_class_in = mmts_pkg::classify(b);
                           if (req_class_in != mmts_pkg::RC_DROP) begin
                              // slave id goes in now, the code byte next cycle
                              idx   = '0;
                              b     = req_first_ff;
                              defer = 1'b1;
                           end
                        end
                     end
                     if (req_class_in == mmts_pkg::RC_HIGH || req_class_in == mmts_pkg::RC_LOW) begin
                        c_high = (req_class_in == mmts_pkg::RC_HIGH);
                        c_wr   = c_high ? hq_wr_ff : lq_wr_ff;
                        c_fill = c_high ? hq_fill_ff : lq_fill_ff;
                        c_size = c_high ? HSIZE : LSIZE;
                        fits   = stage_fits(idx, c_fill, c_size);
                        if (!req_over_in) begin
                           if (fits) begin
                              mem_we      = 1'b1;
                              mem_we_high = c_high;
                              mem_waddr   = wrap_add(SW'(c_wr), SW'(idx) + SW'(4), SW'(c_size));
                              mem_wdata   = b;
                           end else begin
                              req_over_in = 1'b1;
                           end
                        end
                     end
                     if (req_count_ff <= CNTW'(MAX_FRAME_BYTES) || !req_active_ff) begin
                        req_count_in = req_count_in + CNTW'(1);
                     end
                     if (defer) begin
                        eng_in = mmts_pkg::EN_STAGE1;
                     end else if (hold_last_ff &&
                                  (req_class_in == mmts_pkg::RC_HIGH ||
                                   req_class_in == mmts_pkg::RC_LOW) && !req_over_in) begin
                        cmt_k_in = '0;
                        eng_in   = mmts_pkg::EN_COMMIT;
                     end else begin
                        if (hold_last_ff) begin
                           req_active_in = 1'b0;
                        end
                        item_done = 1'b1;
                     end
                  end
                  mmts_pkg::CMD_RX_BYTE: begin
                     item_done = 1'b1;
                     if (mode_ff == mmts_pkg::MODE_RECEIVING) begin
                        if (reply_ff < RW'(RECEIVE_LIMIT)) begin
                           reply_in = reply_ff + RW'(1);
                        end
                        gap_armed_in  = 1'b1;
                        gap_cnt_in    = '0;
                        resp_armed_in = 1'b0;
                        res_load      = 1'b1;
                        res_kind      = mmts_pkg::KIND_RX_BYTE;
                        res_byte      = b;
                        res_len       = mmts_pkg::LEN_W'(reply_in);
                     end
                  end
                  default: begin
                     // transmit done drops what is left of a queued frame
                     item_done = 1'b1;
                     if ((out_src_ff == mmts_pkg::SRC_HIGH || out_src_ff == mmts_pkg::SRC_LOW) &&
                         out_rem_ff != '0) begin
                        if (s_high) begin
                           hq_rd_in   = wrap_add(SW'(hq_rd_ff), SW'(out_rem_ff), SW'(HSIZE));
                           hq_fill_in = hq_fill_ff - out_rem_ff;
                        end else begin
                           lq_rd_in   = wrap_add(SW'(lq_rd_ff), SW'(out_rem_ff), SW'(LSIZE));
                           lq_fill_in = lq_fill_ff - out_rem_ff;
                        end
                     end
                     out_src_in    = mmts_pkg::SRC_NONE;
                     out_rem_in    = '0;
                     mode_in       = mmts_pkg::MODE_RECEIVING;
                     resp_armed_in = 1'b1;
                     resp_cnt_in   = '0;
                     gap_armed_in  = 1'b0;
                     gap_cnt_in    = '0;
                     reply_in      = '0;
                  end
               endcase
            end
         end
         mmts_pkg::EN_HDR0: begin
            len_lo_in = rq;
            mem_raddr = wrap_add(SW'(s_rd), SW'(1), SW'(s_high ? HSIZE : LSIZE));
            eng_in    = mmts_pkg::EN_HDR1;
         end
         mmts_pkg::EN_HDR1: begin
            if (s_high) begin
               hq_rd_in   = rd4;
               hq_fill_in = fill4;
            end else begin
               lq_rd_in   = rd4;
               lq_fill_in = fill4;
            end
            out_rem_in = rem_v;
            out_pos_in = '0;
            hdr_in     = '0;
            mode_in    = mmts_pkg::MODE_SENDING;
            mem_raddr  = rd4;
            if (rem_v != '0) begin
               eng_in = mmts_pkg::EN_EMIT;
            end else begin
               eng_in    = mmts_pkg::EN_DECODE;
               item_done = 1'b1;
            end
         end
         mmts_pkg::EN_EMIT: begin
            if (s_high) begin
               hq_rd_in   = wrap_add(SW'(hq_rd_ff), SW'(1), SW'(HSIZE));
               hq_fill_in = hq_fill_ff - QW'(1);
            end else begin
               lq_rd_in   = wrap_add(SW'(lq_rd_ff), SW'(1), SW'(LSIZE));
               lq_fill_in = lq_fill_ff - QW'(1);
            end
            out_rem_in = out_rem_ff - QW'(1);
            hdr_in     = latch_hdr(hdr_ff, CNTW'(out_pos_ff), rq);
            if (out_pos_ff < 3'd4) begin
               out_pos_in = out_pos_ff + 3'd1;
            end
            res_load  = 1'b1;
            res_kind  = mmts_pkg::KIND_TX_BYTE;
            res_byte  = rq;
            res_fe    = (out_rem_in == '0);
            item_done = 1'b1;
            eng_in    = mmts_pkg::EN_DECODE;
         end
         mmts_pkg::EN_STAGE1: begin
            c_high = (req_class_ff == mmts_pkg::RC_HIGH);
            c_wr   = c_high ? hq_wr_ff : lq_wr_ff;
            c_fill = c_high ? hq_fill_ff : lq_fill_ff;
            c_size = c_high ? HSIZE : LSIZE;
            fits   = stage_fits(CNTW'(1), c_fill, c_size);
            if (!req_over_ff) begin
               if (fits) begin
                  mem_we      = 1'b1;
                  mem_we_high = c_high;
                  mem_waddr   = wrap_add(SW'(c_wr), SW'(5), SW'(c_size));
                  mem_wdata   = hold_byte_ff;
               end else begin
                  req_over_in = 1'b1;
               end
            end
            if (hold_last_ff && !req_over_in) begin
               cmt_k_in = '0;
               eng_in   = mmts_pkg::EN_COMMIT;
            end else begin
               if (hold_last_ff) begin
                  req_active_in = 1'b0;
               end
               item_done = 1'b1;
               eng_in    = mmts_pkg::EN_DECODE;
            end
         end
         mmts_pkg::EN_COMMIT: begin
            // length little endian, then two zero bytes
            c_high      = (req_class_ff == mmts_pkg::RC_HIGH);
            c_wr        = c_high ? hq_wr_ff : lq_wr_ff;
            c_fill      = c_high ? hq_fill_ff : lq_fill_ff;
            c_size      = c_high ? HSIZE : LSIZE;
            mem_we      = 1'b1;
            mem_we_high = c_high;
            mem_waddr   = wrap_add(SW'(c_wr), SW'(cmt_k_ff), SW'(c_size));
            len16       = 16'(req_count_ff);
            unique case (cmt_k_ff)
               2'd0:    mem_wdata = len16[7:0];
               2'd1:    mem_wdata = len16[15:8];
               default: mem_wdata = '0;
            endcase
            if (cmt_k_ff == 2'd3) begin
               if (c_high) begin
                  hq_wr_in   = wrap_add(SW'(c_wr), SW'(req_count_ff) + SW'(4), SW'(c_size));
                  hq_fill_in = QW'(SW'(c_fill) + SW'(req_count_ff) + SW'(4));
               end else begin
                  lq_wr_in   = wrap_add(SW'(c_wr), SW'(req_count_ff) + SW'(4), SW'(c_size));
                  lq_fill_in = QW'(SW'(c_fill) + SW'(req_count_ff) + SW'(4));
               end
               req_active_in = 1'b0;
               item_done     = 1'b1;
               eng_in        = mmts_pkg::EN_DECODE;
            end else begin
               cmt_k_in = cmt_k_ff + 2'd1;
            end
         end
         default: begin
            eng_in = mmts_pkg::EN_DECODE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_gap_ff     <= mmts_pkg::FRAME_GAP_RESET;
         resp_limit_ff    <= mmts_pkg::RESP_LIMIT_RESET;
         silence_ticks_ff <= mmts_pkg::SILENCE_RESET;
         hold_valid_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         mode_ff          <= mmts_pkg::MODE_IDLE;
         eng_ff           <= mmts_pkg::EN_DECODE;
         hq_rd_ff         <= '0;
         hq_wr_ff         <= '0;
         hq_fill_ff       <= '0;
         lq_rd_ff         <= '0;
         lq_wr_ff         <= '0;
         lq_fill_ff       <= '0;
         req_active_ff    <= 1'b0;
         req_over_ff      <= 1'b0;
         req_class_ff     <= mmts_pkg::RC_PENDING;
         req_count_ff     <= '0;
         req_first_ff     <= '0;
         out_src_ff       <= mmts_pkg::SRC_NONE;
         out_rem_ff       <= '0;
         out_pos_ff       <= '0;
         reply_ff         <= '0;
         gap_armed_ff     <= 1'b0;
         resp_armed_ff    <= 1'b0;
         gap_cnt_ff       <= '0;
         resp_cnt_ff      <= '0;
         sil_cnt_ff       <= '0;
         hdr_ff           <= '0;
         cmt_k_ff         <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               mmts_pkg::REG_FRAME_GAP:  frame_gap_ff     <= csr_wdata;
               mmts_pkg::REG_RESP_LIMIT: resp_limit_ff    <= csr_wdata;
               mmts_pkg::REG_SILENCE:    silence_ticks_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            hold_valid_ff <= 1'b1;
         end else if (item_done) begin
            hold_valid_ff <= 1'b0;
         end
         if (res_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         mode_ff       <= mode_in;
         eng_ff        <= eng_in;
         hq_rd_ff      <= hq_rd_in;
         hq_wr_ff      <= hq_wr_in;
         hq_fill_ff    <= hq_fill_in;
         lq_rd_ff      <= lq_rd_in;
         lq_wr_ff      <= lq_wr_in;
         lq_fill_ff    <= lq_fill_in;
         req_active_ff <= req_active_in;
         req_over_ff   <= req_over_in;
         req_class_ff  <= req_class_in;
         req_count_ff  <= req_count_in;
         req_first_ff  <= req_first_in;
         out_src_ff    <= out_src_in;
         out_rem_ff    <= out_rem_in;
         out_pos_ff    <= out_pos_in;
         reply_ff      <= reply_in;
         gap_armed_ff  <= gap_armed_in;
         resp_armed_ff <= resp_armed_in;
         gap_cnt_ff    <= gap_cnt_in;
         resp_cnt_ff   <= resp_cnt_in;
         sil_cnt_ff    <= sil_cnt_in;
         hdr_ff        <= hdr_in;
         cmt_k_ff      <= cmt_k_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      len_lo_ff <= len_lo_in;
      if (req.valid && req.ready) begin
         hold_cmd_ff  <= req.command;
         hold_byte_ff <= req.data_byte;
         hold_last_ff <= req.last_byte;
      end
      if (res_load) begin
         rsp_kind_ff <= res_kind;
         rsp_byte_ff <= res_byte;
         rsp_fe_ff   <= res_fe;
         rsp_len_ff  <= res_len;
         rsp_hdr_ff  <= hdr_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.kind          = rsp_kind_ff;
   assign rsp.out_byte      = rsp_byte_ff;
   assign rsp.frame_end     = rsp_fe_ff;
   assign rsp.reply_length  = rsp_len_ff;
   assign rsp.slave_id      = rsp_hdr_ff.sid;
   assign rsp.function_code = rsp_hdr_ff.fc;
   assign rsp.start_address = rsp_hdr_ff.addr;

`ifndef NO_ASSERTIONS
   a_fill_bounds: assert property (@(posedge clock) disable iff (reset)
      hq_fill_ff <= HSIZE && lq_fill_ff <= LSIZE)
      else $error("queue fill beyond queue size");

   a_result_slot: assert property (@(posedge clock) disable iff (reset)
      res_load |-> (!rsp_valid_ff || rsp.ready))
      else $error("result produced while output register is occupied");

   a_busy_has_item: assert property (@(posedge clock) disable iff (reset)
      (eng_ff != mmts_pkg::EN_DECODE) |-> hold_valid_ff)
      else $error("sequencer busy without a held beat");

   a_single_write: assert property (@(posedge clock) disable iff (reset)
      (eng_ff == mmts_pkg::EN_COMMIT) |-> (req_class_ff == mmts_pkg::RC_HIGH ||
                                           req_class_ff == mmts_pkg::RC_LOW))
      else $error("commit without a queued request class");
`endif

endmodule
